@@ design/chbd_pkg.sv @@
// Package for the chunked body decoder: phase and status codes, item and
// result structs, character class helpers. No dependencies.
`default_nettype none

package chbd_pkg;

    typedef enum logic [2:0] {
        PH_SIZE    = 3'd0,
        PH_DATA    = 3'd1,
        PH_SKIP_CR = 3'd2,
        PH_SKIP_LF = 3'd3,
        PH_DONE    = 3'd4,
        PH_FAIL    = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        ST_DECODING = 2'd0,
        ST_FINAL    = 2'd1,
        ST_FAILED   = 2'd2
    } status_t;

    localparam logic [7:0] CHAR_LF = 8'h0A;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_SP = 8'h20;
    localparam logic [7:0] CHAR_HT = 8'h09;
    localparam logic [7:0] CHAR_VT = 8'h0B;
    localparam logic [7:0] CHAR_FF = 8'h0C;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       restart;
        logic       buffer_last;
    } item_t;

    typedef struct packed {
        logic       payload_valid;
        logic [7:0] out_byte;
        status_t    status;
        logic       buffer_done;
    } result_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.ok    = 1'b1;
        h.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.value = 4'(c - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return c == CHAR_SP || c == CHAR_HT || c == CHAR_VT || c == CHAR_FF
            || c == CHAR_CR;
    endfunction

endpackage

`default_nettype wire

@@ design/http_chunked_body_decoder.sv @@
// Top level of the HTTP chunked body decoder: input register, decode step,
// result register. Uses chbd_pkg, chbd_in_stage and chbd_core.
//
// Usage:
//   s_ carries one body byte per item (tdata), tuser[0] = restart, which
//   returns the decoder to the size line before the byte, and tlast = last
//   byte of a receive buffer.
//   m_ gives exactly one result per input item: tdata = payload byte (zero
//   when not payload), tuser[0] = payload flag, tuser[2:1] = status after
//   the byte (0 decoding, 1 final chunk seen, 2 failed), tlast = echo of
//   the input tlast.
//   Path: an accepted item passes the input register and then the result
//   register before it shows on m_tvalid.
//   Throughput: one item per cycle while m_tready stays high; the decode
//   step is a single combinational pass between the two registers.
//   Reset: aresetn low empties both registers and returns the decoder to
//   the size line with all counts cleared.
//   Stall: while m_tready is low the result holds; one more item may wait
//   in the input register, then s_tready drops.
`default_nettype none

module http_chunked_body_decoder #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // in_byte
    input  wire logic [0:0] s_tuser,   // restart
    input  wire logic       s_tlast,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,   // out_byte
    output logic [2:0]      m_tuser,   // payload_valid, status[1:0]
    output logic            m_tlast
);

    chbd_pkg::item_t   s_item;
    chbd_pkg::item_t   item;
    chbd_pkg::result_t result;
    logic              item_valid;
    logic              out_free;
    logic              step;

    logic              m_valid_reg;
    logic [7:0]        m_data_reg;
    logic [2:0]        m_user_reg;
    logic              m_last_reg;

    assign s_item.in_byte     = s_tdata;
    assign s_item.restart     = s_tuser[0];
    assign s_item.buffer_last = s_tlast;

    assign out_free = !m_valid_reg || m_tready;
    assign step     = item_valid && out_free;

    chbd_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_item     (s_item),
        .take       (out_free),
        .item_valid (item_valid),
        .item       (item)
    );

    chbd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item),
        .result  (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_free) begin
            m_valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            m_data_reg <= result.out_byte;
            m_user_reg <= {result.status, result.payload_valid};
            m_last_reg <= result.buffer_done;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

`ifndef SYNTHESIS
    a_payload_while_decoding: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tuser[2:1] == chbd_pkg::ST_DECODING)
        else $error("payload item with final or failed status");

    a_zero_when_not_payload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tdata == 8'd0)
        else $error("non-payload item carries a nonzero byte");

    a_ready_only_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input held off without an output stall");

    a_step_loads_result: assert property (@(posedge aclk) disable iff (!aresetn)
        step |=> m_tvalid)
        else $error("decoded item lost before the result register");
`endif

endmodule

`default_nettype wire

@@ design/chbd_in_stage.sv @@
// Input register of the chunked body decoder: takes one item from the
// slave stream and holds it until the decode step uses it. Uses chbd_pkg.
`default_nettype none

module chbd_in_stage (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire chbd_pkg::item_t s_item,
    input  wire logic          take,
    output logic               item_valid,
    output chbd_pkg::item_t    item
);

    logic            valid_reg;
    chbd_pkg::item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= s_item;
        end
    end

endmodule

`default_nettype wire

@@ design/chbd_core.sv @@
// Decode step and decoder state of the chunked body decoder: size line
// parsing, payload count and CR/LF skipping. Uses chbd_pkg.
`default_nettype none

module chbd_core #(
    parameter int COUNT_BITS = 32
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            step,
    input  wire chbd_pkg::item_t item,
    output chbd_pkg::result_t    result
);

    chbd_pkg::phase_t        phase_reg, phase_next;
    logic [COUNT_BITS-1:0]   bytes_left_reg, bytes_left_next;
    logic [COUNT_BITS-1:0]   accum_reg, accum_next;
    logic                    seen_reg, seen_next;
    logic                    ended_reg, ended_next;
    logic                    ovf_reg, ovf_next;

    chbd_pkg::phase_t        ph;
    logic [COUNT_BITS-1:0]   bl, acc;
    logic                    seen, ended, ovf;

    chbd_pkg::phase_t        lb_phase;
    logic [COUNT_BITS-1:0]   lb_bytes_left, lb_accum;
    logic                    lb_seen, lb_ended, lb_ovf;
    chbd_pkg::hex_t          hex;
    logic [7:0]              c;

    assign c   = item.in_byte;
    assign hex = chbd_pkg::hex_decode(c);

    // restart clears the decoder before this item is handled
    always_comb begin
        ph    = item.restart ? chbd_pkg::PH_SIZE : phase_reg;
        bl    = item.restart ? '0 : bytes_left_reg;
        acc   = item.restart ? '0 : accum_reg;
        seen  = item.restart ? 1'b0 : seen_reg;
        ended = item.restart ? 1'b0 : ended_reg;
        ovf   = item.restart ? 1'b0 : ovf_reg;
    end

    // one byte of the size line
    always_comb begin
        lb_phase      = chbd_pkg::PH_SIZE;
        lb_bytes_left = bl;
        lb_accum      = acc;
        lb_seen       = seen;
        lb_ended      = ended;
        lb_ovf        = ovf;
        if (c == chbd_pkg::CHAR_LF) begin
            if (!seen || ovf) begin
                lb_phase = chbd_pkg::PH_FAIL;
            end else if (acc == '0) begin
                lb_phase = chbd_pkg::PH_DONE;
            end else begin
                lb_phase      = chbd_pkg::PH_DATA;
                lb_bytes_left = acc;
            end
            lb_accum = '0;
            lb_seen  = 1'b0;
            lb_ended = 1'b0;
            lb_ovf   = 1'b0;
        end else if (!ended) begin
            if (hex.ok) begin
                lb_seen = 1'b1;
                if (!ovf) begin
                    if (acc[COUNT_BITS-1 -: 4] != 4'd0) begin
                        lb_ovf = 1'b1;
                    end else begin
                        lb_accum = {acc[COUNT_BITS-5:0], hex.value};
                    end
                end
            end else if (!(!seen && chbd_pkg::is_blank(c))) begin
                lb_ended = 1'b1;
            end
        end
    end

    always_comb begin
        phase_next      = ph;
        bytes_left_next = bl;
        accum_next      = acc;
        seen_next       = seen;
        ended_next      = ended;
        ovf_next        = ovf;
        result.payload_valid = 1'b0;
        result.out_byte      = 8'd0;
        result.buffer_done   = item.buffer_last;
        unique case (ph) inside
            chbd_pkg::PH_DONE, chbd_pkg::PH_FAIL: begin
            end
            chbd_pkg::PH_DATA: begin
                result.payload_valid = 1'b1;
                result.out_byte      = c;
                if (bl[COUNT_BITS-1:1] == '0) begin
                    bytes_left_next = '0;
                    phase_next      = chbd_pkg::PH_SKIP_CR;
                end else begin
                    bytes_left_next = bl - COUNT_BITS'(1);
                end
            end
            chbd_pkg::PH_SKIP_CR: begin
                if (c == chbd_pkg::CHAR_CR) begin
                    phase_next = chbd_pkg::PH_SKIP_LF;
                end else if (c == chbd_pkg::CHAR_LF) begin
                    phase_next = chbd_pkg::PH_SIZE;
                end else begin
                    phase_next      = lb_phase;
                    bytes_left_next = lb_bytes_left;
                    accum_next      = lb_accum;
                    seen_next       = lb_seen;
                    ended_next      = lb_ended;
                    ovf_next        = lb_ovf;
                end
            end
            chbd_pkg::PH_SKIP_LF: begin
                if (c == chbd_pkg::CHAR_LF) begin
                    phase_next = chbd_pkg::PH_SIZE;
                end else begin
                    phase_next      = lb_phase;
                    bytes_left_next = lb_bytes_left;
                    accum_next      = lb_accum;
                    seen_next       = lb_seen;
                    ended_next      = lb_ended;
                    ovf_next        = lb_ovf;
                end
            end
            default: begin
                phase_next      = lb_phase;
                bytes_left_next = lb_bytes_left;
                accum_next      = lb_accum;
                seen_next       = lb_seen;
                ended_next      = lb_ended;
                ovf_next        = lb_ovf;
            end
        endcase
        if (phase_next == chbd_pkg::PH_FAIL) begin
            result.status = chbd_pkg::ST_FAILED;
        end else if (phase_next == chbd_pkg::PH_DONE) begin
            result.status = chbd_pkg::ST_FINAL;
        end else begin
            result.status = chbd_pkg::ST_DECODING;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= chbd_pkg::PH_SIZE;
            bytes_left_reg <= '0;
            accum_reg      <= '0;
            seen_reg       <= 1'b0;
            ended_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
        end else if (step) begin
            phase_reg      <= phase_next;
            bytes_left_reg <= bytes_left_next;
            accum_reg      <= accum_next;
            seen_reg       <= seen_next;
            ended_reg      <= ended_next;
            ovf_reg        <= ovf_next;
        end
    end

endmodule

`default_nettype wire

@@ tb/chbd_checker.sv @@
`timescale 1ns / 1ps
// Checker for the chunked body decoder: watches both stream channels, predicts
// each result from the accepted byte and compares. Uses chbd_pkg.
module chbd_checker
    import chbd_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    input  logic       s_tready,
    input  logic [7:0] s_tdata,   // in_byte
    input  logic [0:0] s_tuser,   // restart
    input  logic       s_tlast,
    input  logic       m_tvalid,
    input  logic       m_tready,
    input  logic [7:0] m_tdata,   // out_byte
    input  logic [2:0] m_tuser,   // payload_valid, status[1:0]
    input  logic       m_tlast,
    output int         fail_count,
    output int         outstanding
);

    typedef struct packed {
        logic       payload;
        logic [7:0] data;
        status_t    status;
        logic       last;
    } decoded_t;

    decoded_t decoded_q[$];

    phase_t                ph;
    logic [COUNT_BITS-1:0] left;
    logic [COUNT_BITS-1:0] accum;
    logic                  seen;
    logic                  ended;
    logic                  ovf;
    int                    mismatches = 0;
    int                    queued = 0;

    assign fail_count  = mismatches;
    assign outstanding = queued;

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic clear_line();
        accum = '0;
        seen  = 1'b0;
        ended = 1'b0;
        ovf   = 1'b0;
    endtask

    task automatic clear_decoder();
        ph   = PH_SIZE;
        left = '0;
        clear_line();
    endtask

    // bit 4 set when c is a hex digit, value below
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") begin
            return {1'b1, 4'(c - "0")};
        end else if (c >= "a" && c <= "f") begin
            return {1'b1, 4'(c - "a" + 8'd10)};
        end else if (c >= "A" && c <= "F") begin
            return {1'b1, 4'(c - "A" + 8'd10)};
        end
        return 5'd0;
    endfunction

    task automatic size_line_step(input logic [7:0] c);
        logic [4:0] h;
        h = hex_digit(c);
        if (c == CHAR_LF) begin
            if (!seen || ovf) begin
                ph = PH_FAIL;
            end else if (accum == '0) begin
                ph = PH_DONE;
            end else begin
                left = accum;
                ph   = PH_DATA;
            end
            clear_line();
        end else if (!ended) begin
            if (h[4]) begin
                seen = 1'b1;
                if (!ovf) begin
                    if (accum[COUNT_BITS-1 -: 4] != 4'd0) begin
                        ovf = 1'b1;
                    end else begin
                        accum = {accum[COUNT_BITS-5:0], h[3:0]};
                    end
                end
            end else if (seen || !(c inside {CHAR_SP, CHAR_HT, CHAR_VT, CHAR_FF, CHAR_CR})) begin
                ended = 1'b1;
            end
        end
    endtask

    task automatic decode_byte(input logic [7:0] c, input logic rs, input logic last,
                               output decoded_t r);
        r.payload = 1'b0;
        r.data    = 8'd0;
        r.status  = ST_DECODING;
        r.last    = last;
        if (rs) clear_decoder();
        case (ph) inside
            PH_DONE, PH_FAIL: begin
            end
            PH_DATA: begin
                r.payload = 1'b1;
                r.data    = c;
                if (left <= COUNT_BITS'(1)) begin
                    left = '0;
                    ph   = PH_SKIP_CR;
                end else begin
                    left = left - COUNT_BITS'(1);
                end
            end
            PH_SKIP_CR: begin
                if (c == CHAR_CR) begin
                    ph = PH_SKIP_LF;
                end else begin
                    ph = PH_SIZE;
                    if (c != CHAR_LF) size_line_step(c);
                end
            end
            PH_SKIP_LF: begin
                ph = PH_SIZE;
                if (c != CHAR_LF) size_line_step(c);
            end
            default: begin
                ph = PH_SIZE;
                size_line_step(c);
            end
        endcase
        if (ph == PH_FAIL) begin
            r.status = ST_FAILED;
        end else if (ph == PH_DONE) begin
            r.status = ST_FINAL;
        end
    endtask

    always @(posedge aclk) begin : watch
        decoded_t fresh;
        decoded_t oldest;
        if (!aresetn) begin
            clear_decoder();
            decoded_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tuser[0], s_tlast, fresh);
                decoded_q.insert(decoded_q.size(), fresh);
            end
            if (m_tvalid && m_tready) begin
                if (decoded_q.size() == 0) begin
                    report_mismatch("unexpected item, tdata", m_tdata, 8'd0);
                end else begin
                    oldest = decoded_q.pop_front();
                    if (m_tuser[0] !== oldest.payload)
                        report_mismatch("payload flag", 8'(m_tuser[0]), 8'(oldest.payload));
                    if (m_tdata !== oldest.data)
                        report_mismatch("out byte", m_tdata, oldest.data);
                    if (m_tuser[2:1] !== oldest.status)
                        report_mismatch("status", 8'(m_tuser[2:1]), 8'(oldest.status));
                    if (m_tlast !== oldest.last)
                        report_mismatch("buffer done", 8'(m_tlast), 8'(oldest.last));
                end
            end
        end
        queued <= decoded_q.size();
    end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// Top of the chunked body decoder testbench: clock, reset, chunked body
// stimulus with random pacing on both channels, verdict. Uses chbd_pkg, chbd_checker.
module testbench;
    import chbd_pkg::*;

    localparam int COUNT_BITS = 32;
    localparam int BODY_ITEMS = 1800;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'd0;   // in_byte
    logic [0:0] s_tuser  = 1'b0;   // restart
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // out_byte
    logic [2:0] m_tuser;           // payload_valid, status[1:0]
    logic       m_tlast;

    int   mismatches;
    int   outstanding;
    int   items_sent   = 0;
    logic restart_next = 1'b0;
    bit   tx_calm      = 1'b0;
    bit   rx_calm      = 1'b0;
    int   rx_hold      = 0;

    http_chunked_body_decoder #(.COUNT_BITS(COUNT_BITS)) i_dut (.*);

    chbd_checker #(.COUNT_BITS(COUNT_BITS)) i_checker (
        .*,
        .fail_count (mismatches),
        .outstanding(outstanding)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    initial begin
        #2_500_000;
        $display("testbench: FAIL");
        $finish;
    end

    // receiver: random stall after each item, with calm stretches
    always @(posedge aclk) begin : rx_pacing
        int n;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_hold  <= 0;
        end else if (m_tvalid && m_tready) begin
            if ($urandom_range(0, 127) == 0) rx_calm = !rx_calm;
            n = rx_calm ? 0 : $urandom_range(0, 18);
            m_tready <= (n == 0);
            rx_hold  <= n;
        end else if (rx_hold > 1) begin
            rx_hold <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            rx_hold  <= 0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= restart_next;
        s_tlast  <= ($urandom_range(0, 7) == 0);
        restart_next = 1'b0;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
        gap = tx_calm ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic send_crlf();
        send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 4))
            0: return CHAR_SP;
            1: return CHAR_HT;
            2: return CHAR_VT;
            3: return CHAR_FF;
            default: return CHAR_CR;
        endcase
    endfunction

    function automatic logic [7:0] junk_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_LF) b = "#";
        return b;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v, input bit upper);
        if (v < 4'd10) return "0" + 8'(v);
        return (upper ? "A" : "a") + 8'(v) - 8'd10;
    endfunction

    function automatic int hex_len(input logic [35:0] v);
        int k;
        k = 1;
        while (k < 9 && (v >> (4 * k)) != 0) k++;
        return k;
    endfunction

    function automatic int lead_zeros();
        return ($urandom_range(0, 5) == 0) ? $urandom_range(1, 10) : 0;
    endfunction

    function automatic int chunk_size();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    endfunction

    task automatic send_size_line(input logic [35:0] value, input int ndig, input int zeros);
        int i;
        repeat (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0) send_byte(pick_blank());
        repeat (zeros) send_byte("0");
        for (i = ndig - 1; i >= 0; i--)
            send_byte(hex_char(value[4 * i +: 4], 1'($urandom_range(0, 1))));
        case ($urandom_range(0, 7))
            0: send_text(";ext=1");
            1: begin
                send_byte(pick_blank());
                send_text("; a=b");
            end
            2: begin
                send_byte(";");
                repeat ($urandom_range(1, 4)) send_byte(junk_byte());
            end
            default: begin
            end
        endcase
        if ($urandom_range(0, 4) != 0) send_byte(CHAR_CR);
        send_byte(CHAR_LF);
    endtask

    task automatic send_chunk(input int n);
        send_size_line(36'(n), hex_len(36'(n)), lead_zeros());
        repeat (n) send_byte(8'($urandom_range(0, 255)));
        case ($urandom_range(0, 9))
            0: send_byte(CHAR_LF);
            1: send_byte(CHAR_CR);
            2: begin
            end
            default: send_crlf();
        endcase
    endtask

    task automatic send_body();
        restart_next = 1'b1;
        repeat ($urandom_range(1, 4)) send_chunk(chunk_size());
        send_size_line(36'd0, 1, lead_zeros());
        if ($urandom_range(0, 1) != 0) send_crlf();   // ignored once final
    endtask

    task automatic send_broken_body();
        restart_next = 1'b1;
        repeat ($urandom_range(0, 2)) send_chunk(chunk_size());
        case ($urandom_range(0, 5))
            0: begin   // no digit on the line
                case ($urandom_range(0, 2))
                    0: send_text("-7");
                    1: send_byte(pick_blank());
                    default: send_text("g1");
                endcase
                send_byte(CHAR_LF);
            end
            1: send_size_line({4'h1, 32'($urandom)}, 9, 0);
            2: send_size_line(36'hF_FFFF_FFFF, 9, 0);
            3: begin   // prefix reads as size zero
                send_text("0x1f");
                send_crlf();
            end
            4: begin   // huge size, cut short by the next restart
                send_size_line({4'h0, 1'b1, 31'($urandom)}, 8, 0);
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
            default: begin
                send_size_line({4'h0, 32'hFFFF_FFFF}, 8, lead_zeros());
                repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 12)) begin
            restart_next = ($urandom_range(0, 15) == 0);
            send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // leading blanks, extension, payload extremes, bare LF after data
        restart_next = 1'b1;
        send_byte(CHAR_SP);
        send_byte(CHAR_HT);
        send_byte(CHAR_VT);
        send_byte(CHAR_FF);
        send_byte(CHAR_CR);
        send_text("2;e");
        send_crlf();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(CHAR_LF);
        // blank after digit ends the size, final chunk is sticky
        send_text("0 ");
        send_byte(CHAR_LF);
        send_text("Z");
        // sign fails, failure is sticky
        restart_next = 1'b1;
        send_text("-1");
        send_byte(CHAR_LF);
        send_text("q");
        // 0x prefix reads as zero
        restart_next = 1'b1;
        send_text("0x9");
        send_byte(CHAR_LF);

        while (items_sent < BODY_ITEMS) begin
            case ($urandom_range(0, 19))
                0: send_noise();
                1, 2, 3: send_broken_body();
                default: send_body();
            endcase
        end

        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/chbd_pkg.sv
design/chbd_in_stage.sv
design/chbd_core.sv
design/http_chunked_body_decoder.sv
tb/chbd_checker.sv
tb/testbench.sv
